/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; take in with `include "assert_macros.svh"
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/lirs_pkg.sv */
// shared types and constants of the linear interpolation resampler
// no dependencies
package lirs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 20;
    localparam int PHASE_W  = 21;
    localparam int FRAC_W   = 16;

    localparam logic [STEP_W-1:0]  STEP_RESET = 20'd65536;
    localparam logic [STEP_W-1:0]  STEP_MIN   = 20'd8192;
    localparam logic [PHASE_W-1:0] ONE_Q16    = 21'd65536;

    // controller to datapath
    typedef struct packed {
        logic load;    // take the new item
        logic calc;    // form the next result and advance the phase
        logic emit;    // move the formed result into the output register
        logic wrap;    // leave the interpolation span for the clamp span
        logic finish;  // write back the stream state
    } t_lirs_cmd;

    // datapath to controller
    typedef struct packed {
        logic active;    // another result is due in the current span
        logic can_wrap;  // past the span end and the clamp span follows
        logic out_free;  // output register can take a result
    } t_lirs_sts;

endpackage

/* src/lirs_ctrl.sv */
// controller of the resampler: sequences load, calc, emit, span wrap and write-back
// depends on lirs_pkg
module lirs_ctrl
    import lirs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_lirs_sts i_sts,
    output t_lirs_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                priority if (i_sts.active) begin
                    o_cmd.calc = 1'b1;
                    n_state    = S_EMIT;
                end else if (i_sts.can_wrap) begin
                    o_cmd.wrap = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/lirs_dpath.sv */
// datapath of the resampler: step register, stream state, multiplier, output register
// depends on lirs_pkg
module lirs_dpath
    import lirs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step_we,
    input  logic [STEP_W-1:0]          i_step,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_end_of_stream,
    input  t_lirs_cmd                  i_cmd,
    output t_lirs_sts                  o_sts,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last_of_run,
    output logic                       o_stream_done
);

    localparam int PROD_W = 2 * (SAMPLE_W + 1);
    localparam int SUM_W  = PROD_W - FRAC_W;

    logic [STEP_W-1:0]          r_step;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic                       r_have;
    logic                       r_eos;
    logic                       r_seg;     // 0 interpolation span, 1 clamp span
    logic [PHASE_W-1:0]         r_phase;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_base;
    logic                       r_last;
    logic                       r_done;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;
    logic                       r_out_done;

    logic [STEP_W-1:0]          inc;
    logic [PHASE_W-1:0]         phase_next;
    logic                       in_range;
    logic                       next_in_range;
    logic                       next_in_clamp;
    logic                       more;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    sum;

    assign inc           = (r_step < STEP_MIN) ? STEP_MIN : r_step;
    assign in_range      = (r_phase[PHASE_W-1:FRAC_W] == '0);
    assign phase_next    = r_phase + {1'b0, inc};
    assign next_in_range = (phase_next[PHASE_W-1:FRAC_W] == '0);
    // next position lands on the final sample, one span further on
    assign next_in_clamp = (phase_next[PHASE_W-1:FRAC_W+1] == '0) && phase_next[FRAC_W];
    assign more          = next_in_range || (!r_seg && r_eos && next_in_clamp);

    assign diff = {r_cur[SAMPLE_W-1], r_cur} - {r_prev[SAMPLE_W-1], r_prev};
    assign prod = diff * $signed({1'b0, r_phase[FRAC_W-1:0]});
    // floor of product over 2^16, added to the base sample (the previous sample, or the current one in the clamp span)
    assign sum  = {{(SUM_W-SAMPLE_W){r_base[SAMPLE_W-1]}}, r_base}
                + r_prod[PROD_W-1:FRAC_W];

    assign o_sts.active   = in_range && (!r_seg || r_eos);
    assign o_sts.can_wrap = !in_range && !r_seg && r_eos;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_RESET;
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_seg   <= 1'b0;
            r_phase <= '0;
        end else begin
            if (i_step_we) begin
                r_step <= i_step;
            end
            if (i_cmd.load) begin
                r_seg <= !r_have;
            end
            if (i_cmd.calc) begin
                r_phase <= phase_next;
            end
            if (i_cmd.wrap) begin
                r_phase <= r_phase - ONE_Q16;
                r_seg   <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_eos) begin
                    r_prev  <= '0;
                    r_have  <= 1'b0;
                    r_phase <= '0;
                end else begin
                    r_prev  <= r_cur;
                    r_have  <= 1'b1;
                    r_phase <= r_seg ? r_phase : (r_phase - ONE_Q16);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= i_sample_in;
            r_eos <= i_end_of_stream;
        end
        if (i_cmd.calc) begin
            r_prod <= r_seg ? '0 : prod;
            r_base <= r_seg ? r_cur : r_prev;
            r_last <= !more;
            r_done <= !more && r_eos;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= sum[SAMPLE_W-1:0];
            r_out_last   <= r_last;
            r_out_done   <= r_done;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;

endmodule

/* src/linear_interp_resampler_unit.sv */
// top level of the linear interpolation resampler; depends on lirs_pkg, lirs_ctrl, lirs_dpath
// per item: load; per result a multiply (calc) and a move into the output register (emit),
// which waits while the output register holds a stalled result; at end of stream a span
// wrap into the clamp span, and a write-back last; the next item is taken after the write-back
// the output register decouples the sides: a new item is taken while a result waits
// reset (i_rst_n low, synchronous): step back to 1.0, stream state cleared
module linear_interp_resampler_unit
    import lirs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: phase increment, Q4.16
    input  logic                       i_step_we,
    input  logic [STEP_W-1:0]          i_step,
    // input item channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_end_of_stream,
    // result item channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last_of_run,
    output logic                       o_stream_done
);

    // command and status between the controller and the datapath
    t_lirs_cmd cmd;
    t_lirs_sts sts;

    // controller: idle, step decision, emit wait
    lirs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: phase accumulator, one 17x17 multiply per result, output register
    lirs_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_we       (i_step_we),
        .i_step          (i_step),
        .i_sample_in     (i_sample_in),
        .i_end_of_stream (i_end_of_stream),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sample_out    (o_sample_out),
        .o_last_of_run   (o_last_of_run),
        .o_stream_done   (o_stream_done)
    );

endmodule

/* src/lirs_checker.sv */
// port-level checks of the resampler and their bind to the top level
// depends on lirs_pkg and assert_macros.svh
`include "assert_macros.svh"

module lirs_checker
    import lirs_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_stall,
    input logic                       i_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] i_out_sample,
    input logic                       i_out_last,
    input logic                       i_out_done
);

    // end of stream is always the end of the item's run
    `ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, i_out_valid && i_out_done, i_out_last)
    // one item at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && i_out_stall,
        $stable(i_out_sample))

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_stall   (o_stall),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_out_sample (o_sample_out),
    .i_out_last   (o_last_of_run),
    .i_out_done   (o_stream_done)
);
